>>> sv/bss_pkg.sv
package bss_pkg;

	// Configuration port geometry and register indexes.
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 16;
	localparam logic [CFG_IW-1:0] REG_STEP_COUNT = 2'd0;
	localparam logic [CFG_IW-1:0] REG_AMPLITUDE  = 2'd1;
	localparam logic [CFG_IW-1:0] REG_OFFSET     = 2'd2;

	// Field widths.
	localparam int LEVEL_W = 16;
	localparam int BANK_W  = 8;
	localparam int INDEX_W = 8;
	localparam int VALUE_W = 13;
	localparam int COUNT_W = 9;

	// Reset values of the configuration registers.
	localparam logic [COUNT_W-1:0] STEP_COUNT_RST = 9'd16;
	localparam logic [LEVEL_W-1:0] AMPLITUDE_RST  = 16'd4096;
	localparam logic [LEVEL_W-1:0] OFFSET_RST     = 16'd0;

	// Stored values are unsigned Q1.12; this is 1.0, the largest value kept.
	localparam logic [VALUE_W-1:0] VALUE_ONE = 13'd4096;

	// Half of one Q3.12 unit at the Q3.24 product scale, for rounding.
	localparam int PROD_W = 30;
	localparam int RND_W  = 31;
	localparam int FRAC_W = 12;
	localparam logic signed [RND_W-1:0] ROUND_HALF = 31'sd2048;

	// Controller states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FOLD,
		ST_DIV,
		ST_READ,
		ST_MUL,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_wr;
		logic wr_entry;
		logic tick_load;
		logic fold;
		logic div_step;
		logic rd;
		logic mul;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic fold_fast;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

>>> sv/bss_ctrl.sv
module bss_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_action,
	output logic             in_ready,
	input  bss_pkg::status_t sts,
	output bss_pkg::cmd_t    cmd
);

	bss_pkg::state_t state_q;
	bss_pkg::state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bss_pkg::ST_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and command decode.
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			bss_pkg::ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_next = bss_pkg::ST_IDLE;
				end
			end
			bss_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_action) begin
						cmd.wr_entry = 1'b1;
					end else begin
						cmd.tick_load = 1'b1;
						state_next    = bss_pkg::ST_FOLD;
					end
				end
			end
			bss_pkg::ST_FOLD: begin
				cmd.fold = 1'b1;
				if (sts.fold_fast) begin
					state_next = bss_pkg::ST_READ;
				end else begin
					state_next = bss_pkg::ST_DIV;
				end
			end
			bss_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_next = bss_pkg::ST_READ;
				end
			end
			bss_pkg::ST_READ: begin
				cmd.rd     = 1'b1;
				state_next = bss_pkg::ST_MUL;
			end
			bss_pkg::ST_MUL: begin
				cmd.mul    = 1'b1;
				state_next = bss_pkg::ST_OUT;
			end
			bss_pkg::ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_next   = bss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = bss_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> sv/bss_datapath.sv
module bss_datapath #(
	parameter int MAX_STEPS = 256,
	parameter int BANKS     = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [bss_pkg::LEVEL_W-1:0]  in_step_level,
	input  logic signed [bss_pkg::LEVEL_W-1:0]  in_reset_level,
	input  logic        [bss_pkg::BANK_W-1:0]   in_bank,
	input  logic        [bss_pkg::INDEX_W-1:0]  in_step_index,
	input  logic        [bss_pkg::VALUE_W-1:0]  in_write_value,
	input  logic                                cfg_wr,
	input  logic        [bss_pkg::CFG_IW-1:0]   cfg_index,
	input  logic        [bss_pkg::CFG_DW-1:0]   cfg_data,
	input  bss_pkg::cmd_t                       cmd,
	output bss_pkg::status_t                    sts,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic        [bss_pkg::LEVEL_W-1:0]  out_level,
	output logic        [bss_pkg::LEVEL_W-1:0]  out_gate
);

	localparam int PW    = $clog2(MAX_STEPS);
	localparam int DW    = PW + 1;
	localparam int KW    = $clog2(DW);
	localparam int BW    = (BANKS > 1) ? $clog2(BANKS) : 1;
	localparam int DEPTH = BANKS * MAX_STEPS;
	localparam int AW    = $clog2(DEPTH);

	// Configuration registers.
	logic        [bss_pkg::COUNT_W-1:0] step_count_q;
	logic signed [bss_pkg::LEVEL_W-1:0] amp_q;
	logic signed [bss_pkg::LEVEL_W-1:0] off_q;

	// Play state.
	logic        [PW-1:0]               pos_q;
	logic signed [bss_pkg::LEVEL_W-1:0] last_step_q;
	logic signed [bss_pkg::LEVEL_W-1:0] last_reset_q;
	logic                               gate_sent_q;

	// Per-tick working registers.
	logic [DW-1:0] dvd_q;
	logic [DW-1:0] rem_q;
	logic [KW-1:0] div_cnt_q;
	logic [BW-1:0] bank_q;
	logic          gate_pend_q;

	// Pattern memory and its clearing counter.
	logic [bss_pkg::VALUE_W-1:0] mem [DEPTH];
	logic [bss_pkg::VALUE_W-1:0] rd_q;
	logic [AW-1:0]               clr_q;

	logic signed [bss_pkg::PROD_W-1:0] prod_q;

	// Output register.
	logic                        out_valid_q;
	logic [bss_pkg::LEVEL_W-1:0] level_q;
	logic [bss_pkg::LEVEL_W-1:0] gate_q;

	// Combinational values.
	logic [DW-1:0]               cnt;
	logic [DW-1:0]               idx_lim;
	logic [PW-1:0]               idx_c;
	logic [BW-1:0]               bank_c;
	logic [bss_pkg::VALUE_W-1:0] wval;
	logic [AW-1:0]               wr_addr;
	logic [AW-1:0]               rd_addr;
	logic                        step_edge;
	logic                        reset_edge;
	logic [DW-1:0]               dvd_next;
	logic [DW-1:0]               diff;
	logic [PW-1:0]               fast_pos;
	logic [DW-1:0]               rem_sh;
	logic [DW-1:0]               rem_next;

	logic signed [bss_pkg::RND_W-1:0]            rnd;
	logic signed [bss_pkg::RND_W-bss_pkg::FRAC_W-1:0] quo;
	logic signed [bss_pkg::RND_W-bss_pkg::FRAC_W:0]   sum;
	logic        [bss_pkg::LEVEL_W-1:0]          lvl;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q <= bss_pkg::STEP_COUNT_RST;
			amp_q        <= bss_pkg::AMPLITUDE_RST;
			off_q        <= bss_pkg::OFFSET_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				bss_pkg::REG_STEP_COUNT: step_count_q <= cfg_data[bss_pkg::COUNT_W-1:0];
				bss_pkg::REG_AMPLITUDE:  amp_q        <= cfg_data;
				bss_pkg::REG_OFFSET:     off_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective step count, held within 1 to MAX_STEPS.
	always_comb begin
		if (step_count_q == '0) begin
			cnt = DW'(1);
		end else if (32'(step_count_q) > 32'(MAX_STEPS)) begin
			cnt = DW'(MAX_STEPS);
		end else begin
			cnt = DW'(step_count_q);
		end
	end

	// Clamped bank, step index and value for a write transaction.
	assign idx_lim = cnt - DW'(1);
	assign idx_c   = (32'(in_step_index) > 32'(idx_lim)) ? PW'(idx_lim) : PW'(in_step_index);
	assign bank_c  = (32'(in_bank) > 32'(BANKS - 1)) ? BW'(BANKS - 1) : BW'(in_bank);
	assign wval    = (in_write_value > bss_pkg::VALUE_ONE) ? bss_pkg::VALUE_ONE : in_write_value;
	assign wr_addr = AW'(bank_c) * AW'(MAX_STEPS) + AW'(idx_c);
	assign rd_addr = AW'(bank_q) * AW'(MAX_STEPS) + AW'(pos_q);

	// Trigger edges and the unfolded next position.
	assign step_edge  = (last_step_q <= 16'sd0) && (in_step_level > 16'sd0);
	assign reset_edge = (last_reset_q <= 16'sd0) && (in_reset_level > 16'sd0);

	always_comb begin
		if (reset_edge) begin
			dvd_next = '0;
		end else if (step_edge) begin
			dvd_next = DW'(pos_q) + DW'(1);
		end else begin
			dvd_next = DW'(pos_q);
		end
	end

	// Fold: at most one subtraction resolves the common cases.
	assign diff          = dvd_q - cnt;
	assign sts.fold_fast = (dvd_q < cnt) || (diff < cnt);
	assign fast_pos      = (dvd_q < cnt) ? dvd_q[PW-1:0] : diff[PW-1:0];

	// Restoring remainder, one dividend bit per cycle.
	assign rem_sh       = {rem_q[DW-2:0], dvd_q[DW-1]};
	assign rem_next     = (rem_sh >= cnt) ? rem_sh - cnt : rem_sh;
	assign sts.div_last = (div_cnt_q == KW'(DW - 1));

	// Play state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			last_step_q  <= '0;
			last_reset_q <= '0;
			gate_sent_q  <= 1'b0;
		end else begin
			if (cmd.tick_load) begin
				last_step_q  <= in_step_level;
				last_reset_q <= in_reset_level;
				gate_sent_q  <= 1'b1;
			end
			if (cmd.fold && sts.fold_fast) begin
				pos_q <= fast_pos;
			end
			if (cmd.div_step && sts.div_last) begin
				pos_q <= rem_next[PW-1:0];
			end
		end
	end

	// Working registers of one tick.
	always_ff @(posedge clk) begin
		if (cmd.tick_load) begin
			dvd_q       <= dvd_next;
			bank_q      <= bank_c;
			gate_pend_q <= !gate_sent_q || step_edge || reset_edge;
		end
		if (cmd.fold) begin
			rem_q     <= '0;
			div_cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q     <= rem_next;
			dvd_q     <= {dvd_q[DW-2:0], 1'b0};
			div_cnt_q <= div_cnt_q + KW'(1);
		end
	end

	// Clearing pass counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	assign sts.clr_last = (clr_q == AW'(DEPTH - 1));

	// Pattern memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			mem[clr_q] <= '0;
		end else if (cmd.wr_entry) begin
			mem[wr_addr] <= wval;
		end
		if (cmd.rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Scale the stored value.
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= bss_pkg::PROD_W'(amp_q) * bss_pkg::PROD_W'($signed({1'b0, rd_q}));
		end
	end

	// Round to Q3.12, add the offset and saturate.
	assign rnd = bss_pkg::RND_W'(prod_q) + bss_pkg::ROUND_HALF;
	assign quo = $signed(rnd[bss_pkg::RND_W-1:bss_pkg::FRAC_W]);
	assign sum = (bss_pkg::RND_W - bss_pkg::FRAC_W + 1)'(quo)
		+ (bss_pkg::RND_W - bss_pkg::FRAC_W + 1)'(off_q);

	always_comb begin
		if (sum > 20'sd32767) begin
			lvl = 16'h7FFF;
		end else if (sum < -20'sd32768) begin
			lvl = 16'h8000;
		end else begin
			lvl = sum[bss_pkg::LEVEL_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			level_q <= lvl;
			gate_q  <= gate_pend_q ? lvl : off_q;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_level    = level_q;
	assign out_gate     = gate_q;

endmodule

>>> sv/banked_step_sequencer.sv
// Write transaction: the controller stays idle, so the next transaction may follow directly.
// Tick transaction: fold, read, multiply and output states follow, and no new transaction
// is taken until the result is registered; when the position reaches twice the step count
// or more, the fold divides serially. The pattern memory has one read port, read once per tick.
// Reset (arst_n low) clears all control state; then a clearing pass writes zero to all
// BANKS*MAX_STEPS pattern entries, one per cycle, with s_axis_tready low.
module banked_step_sequencer #(
	parameter int MAX_STEPS = 256,
	parameter int BANKS     = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// tdata: step_level[15:0], reset_level[31:16], bank[39:32], step_index[47:40],
	// write_value[60:48], zero[63:61]
	input  logic [63:0] s_axis_tdata,
	// tuser: action[0]
	input  logic        s_axis_tuser,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: level_out[15:0], gate_out[31:16]
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic        cfg_wr,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	bss_pkg::cmd_t    cmd;
	bss_pkg::status_t sts;
	logic [bss_pkg::LEVEL_W-1:0] level;
	logic [bss_pkg::LEVEL_W-1:0] gate;

	// Sequencing of clear, write and tick transactions.
	bss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_action (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Pattern memory, position logic and output arithmetic.
	bss_datapath #(
		.MAX_STEPS (MAX_STEPS),
		.BANKS     (BANKS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_step_level  (s_axis_tdata[15:0]),
		.in_reset_level (s_axis_tdata[31:16]),
		.in_bank        (s_axis_tdata[39:32]),
		.in_step_index  (s_axis_tdata[47:40]),
		.in_write_value (s_axis_tdata[60:48]),
		.cfg_wr         (cfg_wr),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.sts            (sts),
		.out_ready      (m_axis_tready),
		.out_valid      (m_axis_tvalid),
		.out_level      (level),
		.out_gate       (gate)
	);

	assign m_axis_tdata = {gate, level};

endmodule

>>> verif/tb_banked_step_sequencer.sv
`timescale 1ns / 1ps

module tb_banked_step_sequencer;

	localparam int MAX_STEPS    = 256;
	localparam int BANKS        = 256;
	localparam int DRAIN_CYCLES = 32;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 200000;

	// Index with no register behind it; writes to it must be ignored.
	localparam logic [bss_pkg::CFG_IW-1:0] REG_NONE = 2'd3;

	// Item kinds as carried on tuser.
	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_WRITE,
		ROW_TICK
	} row_kind_t;

	// One row of the directed sequence; t_level/t_gate hold a hand-worked result.
	typedef struct packed {
		row_kind_t                  kind;
		logic [bss_pkg::CFG_IW-1:0] reg_idx;
		logic [bss_pkg::CFG_DW-1:0] reg_val;
		logic [15:0]                stl;
		logic [15:0]                rsl;
		logic [7:0]                 bk;
		logic [7:0]                 ix;
		logic [12:0]                wv;
		logic                       typed;
		logic [15:0]                t_level;
		logic [15:0]                t_gate;
	} dir_row_t;

	// Same layout as the result tdata: level_out low, gate_out high.
	typedef struct packed {
		logic [15:0] gate;
		logic [15:0] level;
	} step_out_t;

	logic        clk;
	logic        arst_n;
	logic [63:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic        cfg_wr;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	banked_step_sequencer #(
		.MAX_STEPS(MAX_STEPS),
		.BANKS    (BANKS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_wr       (cfg_wr),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Shadow copy of the sequencer state and registers.
	logic [12:0]        pat_mem [BANKS*MAX_STEPS];
	int                 play_pos;
	logic signed [15:0] prev_step;
	logic signed [15:0] prev_rst;
	bit                 gate_done;
	logic [8:0]         cfg_count;
	logic signed [15:0] cfg_amp;
	logic signed [15:0] cfg_off;

	step_out_t step_results_q [$];
	int        mismatch_cnt;
	int        stall_cycles;
	bit        tx_idle_on;
	bit        rx_idle_on;
	bit        hold_req;

	// Hand-worked result carried alongside the transaction in flight.
	logic        item_typed;
	logic [15:0] typed_level;
	logic [15:0] typed_gate;

	// Directed sequence: extremes, clamps, saturation, ignored index and fold.
	dir_row_t dir_rows [25] = '{
		'{ROW_TICK,  REG_NONE, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd0, 13'd0,
			1'b1, 16'h0000, 16'h0000},
		'{ROW_WRITE, REG_NONE, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd0, 13'd4096,
			1'b0, 16'h0000, 16'h0000},
		'{ROW_WRITE, REG_NONE, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd1, 13'd8191,
			1'b0, 16'h0000, 16'h0000},
		'{ROW_WRITE, REG_NONE, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd255, 13'd2048,
			1'b0, 16'h0000, 16'h0000},
		'{ROW_WRITE, REG_NONE, 16'h0000, 16'h0000, 16'h0000, 8'd255, 8'd0, 13'd4095,
			1'b0, 16'h0000, 16'h0000},
		'{ROW_TICK,  REG_NONE, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd0, 13'd0,
			1'b1, 16'h1000, 16'h0000},
		'{ROW_TICK,  REG_NONE, 16'h0000, 16'h7FFF, 16'h0000, 8'd0, 8'd0, 13'd0,
			1'b1, 16'h1000, 16'h1000},
		'{ROW_TICK,  REG_NONE, 16'h0000, 16'h8000, 16'h0000, 8'd255, 8'd0, 13'd0,
			1'b0, 16'h0000, 16'h0000},
		'{ROW_TICK,  REG_NONE, 16'h0000, 16'h0001, 16'hFFFF, 8'd0, 8'd0, 13'd0,
			1'b0, 16'h0000, 16'h0000},
		'{ROW_TICK,  REG_NONE, 16'h0000, 16'hFFFF, 16'h7FFF, 8'd255, 8'd0, 13'd0,
			1'b0, 16'h0000, 16'h0000},
		'{ROW_CFG,   bss_pkg::REG_AMPLITUDE, 16'h8000, 16'h0000, 16'h0000, 8'd0, 8'd0, 13'd0,
			1'b0, 16'h0000, 16'h0000},
		'{ROW_CFG,   bss_pkg::REG_OFFSET, 16'h8000, 16'h0000, 16'h0000, 8'd0, 8'd0, 13'd0,
			1'b0, 16'h0000, 16'h0000},
		'{ROW_TICK,  REG_NONE, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd0, 13'd0,
			1'b1, 16'h8000, 16'h8000},
		'{ROW_CFG,   bss_pkg::REG_AMPLITUDE, 16'h7FFF, 16'h0000, 16'h0000, 8'd0, 8'd0, 13'd0,
			1'b0, 16'h0000, 16'h0000},
		'{ROW_CFG,   bss_pkg::REG_OFFSET, 16'h7FFF, 16'h0000, 16'h0000, 8'd0, 8'd0, 13'd0,
			1'b0, 16'h0000, 16'h0000},
		'{ROW_TICK,  REG_NONE, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd0, 13'd0,
			1'b1, 16'h7FFF, 16'h7FFF},
		'{ROW_CFG,   REG_NONE, 16'hFFFF, 16'h0000, 16'h0000, 8'd0, 8'd0, 13'd0,
			1'b0, 16'h0000, 16'h0000},
		'{ROW_TICK,  REG_NONE, 16'h0000, 16'h0005, 16'h0000, 8'd0, 8'd0, 13'd0,
			1'b0, 16'h0000, 16'h0000},
		'{ROW_TICK,  REG_NONE, 16'h0000, 16'hFFFB, 16'h0000, 8'd0, 8'd0, 13'd0,
			1'b0, 16'h0000, 16'h0000},
		'{ROW_TICK,  REG_NONE, 16'h0000, 16'h0005, 16'h0000, 8'd0, 8'd0, 13'd0,
			1'b0, 16'h0000, 16'h0000},
		'{ROW_CFG,   bss_pkg::REG_STEP_COUNT, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd0, 13'd0,
			1'b0, 16'h0000, 16'h0000},
		'{ROW_TICK,  REG_NONE, 16'h0000, 16'h0005, 16'h0000, 8'd0, 8'd0, 13'd0,
			1'b0, 16'h0000, 16'h0000},
		'{ROW_CFG,   bss_pkg::REG_STEP_COUNT, 16'h8107, 16'h0000, 16'h0000, 8'd0, 8'd0, 13'd0,
			1'b0, 16'h0000, 16'h0000},
		'{ROW_WRITE, REG_NONE, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd255, 13'h0AAA,
			1'b0, 16'h0000, 16'h0000},
		'{ROW_TICK,  REG_NONE, 16'h0000, 16'h8000, 16'h8000, 8'd128, 8'd0, 13'd0,
			1'b0, 16'h0000, 16'h0000}
	};

	// The step count as the block uses it, clamped to 1..MAX_STEPS.
	function automatic int eff_steps();
		if (cfg_count == 0) return 1;
		if (cfg_count > MAX_STEPS) return MAX_STEPS;
		return int'(cfg_count);
	endfunction

	// Applies one input transaction to the shadow state and returns its result, if any.
	function automatic void sequencer_advance(input logic act, input logic [15:0] stl,
		input logic [15:0] rsl, input logic [7:0] bk, input logic [7:0] ix,
		input logic [12:0] wv, output logic produced, output step_out_t res);
		int                 cnt;
		int                 b;
		int                 widx;
		logic [12:0]        v;
		longint             prod;
		longint             sum;
		logic signed [15:0] lvl;

		cnt = eff_steps();
		b = (int'(bk) > BANKS - 1) ? BANKS - 1 : int'(bk);
		res = '0;
		produced = 1'b0;

		// Pattern edit: clamp index and value, nothing else changes.
		if (act == ACT_WRITE) begin
			widx = (int'(ix) > cnt - 1) ? cnt - 1 : int'(ix);
			v = (wv > bss_pkg::VALUE_ONE) ? bss_pkg::VALUE_ONE : wv;
			pat_mem[b*MAX_STEPS + widx] = v;
			return;
		end

		// Trigger edges: step first, then reset, then fold into range.
		if (prev_step <= 0 && $signed(stl) > 0) begin
			play_pos = (play_pos + 1) % cnt;
			gate_done = 1'b0;
		end
		prev_step = stl;
		if (prev_rst <= 0 && $signed(rsl) > 0) begin
			play_pos = 0;
			gate_done = 1'b0;
		end
		prev_rst = rsl;
		if (play_pos >= cnt) play_pos = play_pos % cnt;

		// Q3.24 product, rounded half up to Q3.12, offset added, then saturated.
		prod = longint'(cfg_amp) * longint'(pat_mem[b*MAX_STEPS + play_pos]) + 2048;
		sum = (prod >>> bss_pkg::FRAC_W) + longint'(cfg_off);
		if (sum > 32767) sum = 32767;
		if (sum < -32768) sum = -32768;
		lvl = sum[15:0];

		res.level = lvl;
		if (!gate_done) begin
			res.gate = lvl;
			gate_done = 1'b1;
		end else begin
			res.gate = cfg_off;
		end
		produced = 1'b1;
	endfunction

	// Clock.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				m_axis_tready <= !(rx_idle_on && $urandom_range(0, 99) < 28);
			end
		end
	end

	// Tracks register writes, predicts each accepted item and checks each result.
	always @(posedge clk) begin
		step_out_t got;
		step_out_t want;
		step_out_t pred;
		logic      made;

		if (arst_n) begin
			if (cfg_wr) begin
				case (cfg_index)
					bss_pkg::REG_STEP_COUNT: cfg_count = cfg_data[bss_pkg::COUNT_W-1:0];
					bss_pkg::REG_AMPLITUDE:  cfg_amp = cfg_data;
					bss_pkg::REG_OFFSET:     cfg_off = cfg_data;
					default: ;
				endcase
			end

			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (step_results_q.size() == 0) begin
					$display("%0t: unexpected result level_out %0d gate_out %0d", $time,
						$signed(got.level), $signed(got.gate));
					mismatch_cnt++;
				end else begin
					want = step_results_q.pop_front();
					if (got.level !== want.level) begin
						$display("%0t: level_out expected %0d actual %0d", $time,
							$signed(want.level), $signed(got.level));
						mismatch_cnt++;
					end
					if (got.gate !== want.gate) begin
						$display("%0t: gate_out expected %0d actual %0d", $time,
							$signed(want.gate), $signed(got.gate));
						mismatch_cnt++;
					end
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				sequencer_advance(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
					s_axis_tdata[39:32], s_axis_tdata[47:40], s_axis_tdata[60:48],
					made, pred);
				if (made) begin
					if (item_typed) begin
						pred.level = typed_level;
						pred.gate = typed_gate;
					end
					step_results_q.push_back(pred);
				end
			end
		end
	end

	// Watchdog on cycles without any transaction or register write.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Offers one item, with a random gap before it, and returns at the next falling edge.
	task automatic send_item(input logic act, input logic [15:0] stl, input logic [15:0] rsl,
		input logic [7:0] bk, input logic [7:0] ix, input logic [12:0] wv,
		input logic typed, input logic [15:0] tl, input logic [15:0] tg);
		while (tx_idle_on && $urandom_range(0, 99) < 28) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata <= {3'b000, wv, ix, bk, rsl, stl};
		s_axis_tuser <= act;
		item_typed <= typed;
		typed_level <= tl;
		typed_gate <= tg;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Waits until every predicted result has arrived and the block has settled.
	task automatic wait_drained();
		while (step_results_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Register write while the block is idle.
	task automatic write_reg(input logic [bss_pkg::CFG_IW-1:0] idx,
		input logic [bss_pkg::CFG_DW-1:0] data);
		s_axis_tvalid <= 1'b0;
		wait_drained();
		cfg_wr <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_wr <= 1'b0;
	endtask

	// Random mix of pattern edits and ticks, most of them on a few banks.
	task automatic run_random(input int n_items);
		int          cnt;
		int          lim;
		int          r;
		logic [15:0] stl;
		logic [15:0] rsl;
		logic [7:0]  bk;
		logic [7:0]  ix;
		logic [12:0] wv;

		for (int i = 0; i < n_items; i++) begin
			cnt = eff_steps();
			lim = (cnt - 1 < 40) ? cnt - 1 : 40;
			bk = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, 3));

			if ($urandom_range(0, 99) < 35) begin
				r = $urandom_range(0, 99);
				if (r < 60) ix = 8'($urandom_range(0, lim));
				else if (r < 90) ix = 8'($urandom_range(0, cnt - 1));
				else ix = 8'($urandom_range(0, 255));
				r = $urandom_range(0, 99);
				if (r < 15) wv = 13'd0;
				else if (r < 30) wv = bss_pkg::VALUE_ONE;
				else if (r < 75) wv = 13'($urandom_range(0, 4096));
				else wv = 13'($urandom);
				send_item(ACT_WRITE, 16'($urandom), 16'($urandom), bk, ix, wv,
					1'b0, 16'h0000, 16'h0000);
			end else begin
				// Step level flips sign often; reset rises now and then.
				r = $urandom_range(0, 99);
				if (r < 45) stl = 16'($urandom_range(1, 32767));
				else if (r < 90) stl = 16'(-int'($urandom_range(0, 32768)));
				else stl = 16'($urandom);
				r = $urandom_range(0, 99);
				if (r < 12) rsl = 16'($urandom_range(1, 32767));
				else if (r < 92) rsl = 16'(-int'($urandom_range(0, 32768)));
				else rsl = 16'($urandom);
				send_item(ACT_TICK, stl, rsl, bk, 8'($urandom), 13'($urandom),
					1'b0, 16'h0000, 16'h0000);
			end
		end
	endtask

	// Main sequence.
	initial begin
		arst_n = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = ACT_TICK;
		s_axis_tvalid = 1'b0;
		cfg_wr = 1'b0;
		cfg_index = bss_pkg::REG_STEP_COUNT;
		cfg_data = '0;
		item_typed = 1'b0;
		typed_level = '0;
		typed_gate = '0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		hold_req = 1'b0;
		mismatch_cnt = 0;
		stall_cycles = 0;

		foreach (pat_mem[i]) pat_mem[i] = '0;
		play_pos = 0;
		prev_step = '0;
		prev_rst = '0;
		gate_done = 1'b0;
		cfg_count = bss_pkg::STEP_COUNT_RST;
		cfg_amp = bss_pkg::AMPLITUDE_RST;
		cfg_off = bss_pkg::OFFSET_RST;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The pattern memory is cleared after reset before input is taken.
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			else
				send_item((dir_rows[i].kind == ROW_WRITE) ? ACT_WRITE : ACT_TICK,
					dir_rows[i].stl, dir_rows[i].rsl, dir_rows[i].bk, dir_rows[i].ix,
					dir_rows[i].wv, dir_rows[i].typed, dir_rows[i].t_level,
					dir_rows[i].t_gate);
		end

		// Register reset values, restored by hand.
		write_reg(bss_pkg::REG_STEP_COUNT, 16'd16);
		write_reg(bss_pkg::REG_AMPLITUDE, 16'h1000);
		write_reg(bss_pkg::REG_OFFSET, 16'h0000);
		run_random(120);

		// Short sequence, so the position folds after the shrink.
		write_reg(bss_pkg::REG_STEP_COUNT, 16'd4);
		write_reg(bss_pkg::REG_AMPLITUDE, 16'h7FFF);
		write_reg(bss_pkg::REG_OFFSET, 16'hFF9C);
		run_random(100);

		write_reg(bss_pkg::REG_STEP_COUNT, 16'd256);
		write_reg(bss_pkg::REG_AMPLITUDE, 16'h8000);
		write_reg(bss_pkg::REG_OFFSET, 16'h7FFF);
		run_random(100);

		// Full rate on both sides; unit amplitude exercises rounding ties.
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		write_reg(bss_pkg::REG_STEP_COUNT, 16'd1);
		write_reg(bss_pkg::REG_AMPLITUDE, 16'h0001);
		write_reg(bss_pkg::REG_OFFSET, 16'h0000);
		run_random(80);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;

		// Oversized step count while the result side holds off for a long stretch.
		write_reg(bss_pkg::REG_STEP_COUNT, 16'd300);
		write_reg(bss_pkg::REG_AMPLITUDE, 16'($urandom));
		write_reg(bss_pkg::REG_OFFSET, 16'($urandom));
		hold_req = 1'b1;
		run_random(100);

		// Sender pauses midway until every result is back.
		write_reg(bss_pkg::REG_STEP_COUNT, 16'd7);
		write_reg(bss_pkg::REG_AMPLITUDE, 16'hFFFF);
		write_reg(bss_pkg::REG_OFFSET, 16'h8000);
		run_random(50);
		s_axis_tvalid <= 1'b0;
		wait_drained();
		run_random(50);

		write_reg(bss_pkg::REG_STEP_COUNT, 16'd0);
		write_reg(bss_pkg::REG_AMPLITUDE, 16'($urandom));
		write_reg(bss_pkg::REG_OFFSET, 16'($urandom));
		run_random(60);

		s_axis_tvalid <= 1'b0;
		wait_drained();
		if (mismatch_cnt == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
